>>> sv/apld_pkg.sv
// shared types and constants for the ac pulse loss detector
package apld_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned COUNT_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BLANK_TICKS    = 3'd0,
    CFG_SAMPLE_TICKS   = 3'd1,
    CFG_WINDOW_TICKS   = 3'd2,
    CFG_MIN_PULSES     = 3'd3,
    CFG_INITIAL_PULSES = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] BLANK_TICKS_RST    = 16'd2000;
  localparam logic [7:0]  SAMPLE_TICKS_RST   = 8'd5;
  localparam logic [15:0] WINDOW_TICKS_RST   = 16'd1000;
  localparam logic [7:0]  MIN_PULSES_RST     = 8'd10;
  localparam logic [7:0]  INITIAL_PULSES_RST = 8'd50;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [15:0] blank_ticks;
    logic [7:0]  sample_ticks;
    logic [15:0] window_ticks;
    logic [7:0]  min_pulses;
    logic [7:0]  initial_pulses;
    logic        init_load;
  } cfg_t;

endpackage

>>> sv/ac_pulse_loss_detector.sv
// ac pulse loss detector top level: pin sampler, pulse counter and window verdict
// an accepted request's result is held in the output register in the cycle after it is accepted
// throughput: one request per cycle while in_stall is low, set by the single compare-and-update pass on the state
// the output register stalls the input only while a result is held and out_stall is high
// reset: synchronous; registers to defaults, count to the initial value, verdict healthy
module ac_pulse_loss_detector
  import apld_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              in_now_ticks,
  input  logic                     in_pin_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_fuse_fault,
  output logic                     out_fault_changed,
  output logic                     out_window_closed,
  output logic [COUNT_BITS-1:0]    out_window_pulses,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;

  logic [TIME_BITS-1:0]  last_sample_r;
  logic [TIME_BITS-1:0]  last_window_r;
  logic [COUNT_BITS-1:0] pulse_count_r;
  logic                  seen_low_r;
  logic                  fault_r;
  logic                  out_valid_r;
  logic                  fuse_fault_r;
  logic                  fault_changed_r;
  logic                  window_closed_r;
  logic [COUNT_BITS-1:0] window_pulses_r;

  logic                  acc;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  el_sample;
  logic [TIME_BITS-1:0]  el_window;
  logic                  do_sample;
  logic                  close;
  logic                  pulse;
  logic                  verdict;
  logic                  seen_low_nxt;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] pulse_count_nxt;
  logic                  fault_nxt;

  apld_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_stall = out_valid_r && out_stall;
  assign acc = in_valid && !in_stall;

  assign now_t     = in_now_ticks[TIME_BITS-1:0];
  assign el_sample = now_t - last_sample_r;
  assign el_window = now_t - last_window_r;
  assign do_sample = (now_t >= TIME_BITS'(cfg.blank_ticks))
                     && (el_sample >= TIME_BITS'(cfg.sample_ticks));
  assign close = do_sample && (el_window >= TIME_BITS'(cfg.window_ticks));

  // low then high counts one pulse
  assign pulse = seen_low_r && in_pin_level;
  assign count_inc = (pulse && pulse_count_r != COUNT_MAX) ? pulse_count_r + 1'b1
                                                            : pulse_count_r;

  always_comb begin
    seen_low_nxt    = seen_low_r;
    pulse_count_nxt = pulse_count_r;
    fault_nxt       = fault_r;
    verdict         = count_inc < COUNT_BITS'(cfg.min_pulses);
    if (do_sample) begin
      seen_low_nxt    = seen_low_r ? !in_pin_level : !in_pin_level;
      pulse_count_nxt = count_inc;
      if (close) begin
        seen_low_nxt    = 1'b0;
        pulse_count_nxt = '0;
        fault_nxt       = verdict;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_window_r <= '0;
      pulse_count_r <= COUNT_BITS'(INITIAL_PULSES_RST);
      seen_low_r    <= 1'b0;
      fault_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (acc) begin
        if (do_sample) begin
          last_sample_r <= now_t;
        end
        if (close) begin
          last_window_r <= now_t;
        end
        seen_low_r    <= seen_low_nxt;
        pulse_count_r <= pulse_count_nxt;
        fault_r       <= fault_nxt;
      end
      if (cfg.init_load) begin
        pulse_count_r <= COUNT_BITS'(cfg.initial_pulses);
      end
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fuse_fault_r    <= fault_nxt;
      fault_changed_r <= fault_nxt != fault_r;
      window_closed_r <= close;
      window_pulses_r <= close ? count_inc : pulse_count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fuse_fault    = fuse_fault_r;
  assign out_fault_changed = fault_changed_r;
  assign out_window_closed = window_closed_r;
  assign out_window_pulses = window_pulses_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_change_needs_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fault_changed_r) |-> window_closed_r)
    else $error("verdict changed without a window close");

  a_close_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && close && !cfg.init_load) |=> (pulse_count_r == '0 && !seen_low_r))
    else $error("window close did not clear the counter");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !acc) |=> !out_valid_r)
    else $error("taken result still shown as valid");

  a_fault_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (fuse_fault_r == fault_r))
    else $error("reported verdict differs from held verdict");

endmodule

>>> sv/apld_cfg.sv
// configuration register file of the ac pulse loss detector
module apld_cfg
  import apld_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  logic [15:0] blank_ticks_r;
  logic [7:0]  sample_ticks_r;
  logic [15:0] window_ticks_r;
  logic [7:0]  min_pulses_r;
  logic [7:0]  initial_pulses_r;
  logic        wr;
  logic        init_load;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;
  assign init_load = wr && (cfg_idx_t'(cfg_index) == CFG_INITIAL_PULSES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_ticks_r    <= BLANK_TICKS_RST;
      sample_ticks_r   <= SAMPLE_TICKS_RST;
      window_ticks_r   <= WINDOW_TICKS_RST;
      min_pulses_r     <= MIN_PULSES_RST;
      initial_pulses_r <= INITIAL_PULSES_RST;
    end else if (wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLANK_TICKS:    blank_ticks_r    <= cfg_data;
        CFG_SAMPLE_TICKS:   sample_ticks_r   <= cfg_data[7:0];
        CFG_WINDOW_TICKS:   window_ticks_r   <= cfg_data;
        CFG_MIN_PULSES:     min_pulses_r     <= cfg_data[7:0];
        CFG_INITIAL_PULSES: initial_pulses_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // the counter reloads from the write data in the same edge
  assign cfg.blank_ticks    = blank_ticks_r;
  assign cfg.sample_ticks   = sample_ticks_r;
  assign cfg.window_ticks   = window_ticks_r;
  assign cfg.min_pulses     = min_pulses_r;
  assign cfg.initial_pulses = init_load ? cfg_data[7:0] : initial_pulses_r;
  assign cfg.init_load      = init_load;

endmodule
